// ===== hdl/periodic_timer_bank_macros.svh =====
// Assertion helpers shared by the timer bank modules.
`ifndef PERIODIC_TIMER_BANK_MACROS_SVH
`define PERIODIC_TIMER_BANK_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define PTB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("periodic_timer_bank assertion failed");

// Condition a implies condition b in the next cycle.
`define PTB_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  `PTB_ASSERT(lbl, clk, rstn, (a) |=> (b))

`endif

// ===== hdl/ptb_pkg.sv =====
`default_nettype none
package ptb_pkg;

  localparam int unsigned TIMER_W = 3;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned ACT_W   = 3;
  localparam logic [COUNT_W-1:0] PERIOD_RESET = 32'd1000;

  typedef enum logic [ACT_W-1:0] {
    ACT_POLL  = 3'd0,
    ACT_INIT  = 3'd1,
    ACT_RESET = 3'd2,
    ACT_STOP  = 3'd3,
    ACT_SETCB = 3'd4
  } ptb_action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LOAD,
    S_CATCH,
    S_FLUSH
  } ptb_state_e;

  typedef struct packed {
    logic [TIMER_W-1:0] timer;
    logic [COUNT_W-1:0] count;
  } ptb_res_t;

  typedef struct packed {
    logic     push;
    logic     flush;
    ptb_res_t res;
  } ptb_out_ctl_t;

  typedef struct packed {
    logic stall;
    logic pend_valid;
  } ptb_out_stat_t;

endpackage
`default_nettype wire

// ===== hdl/ptb_ram.sv =====
`default_nettype none
module ptb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/ptb_out.sv =====
`default_nettype none
`include "periodic_timer_bank_macros.svh"
module ptb_out (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ptb_pkg::ptb_out_ctl_t  ctl_i,
  output ptb_pkg::ptb_out_stat_t      stat_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [ptb_pkg::TIMER_W-1:0] expired_timer_o,
  output logic [ptb_pkg::COUNT_W-1:0] tick_count_o,
  output logic                        last_o
);
  import ptb_pkg::*;

  // one word is held back until the next one or the end of the poll shows its last flag
  logic     pend_valid_q;
  ptb_res_t pend_q;
  logic     out_valid_q;
  ptb_res_t out_q;
  logic     out_last_q;
  logic     out_free;
  logic     stall;
  logic     do_push;
  logic     do_flush;
  logic     move;

  assign out_free = !out_valid_q || out_ready_i;
  assign stall    = pend_valid_q && !out_free;
  assign do_push  = ctl_i.push && !stall;
  assign do_flush = ctl_i.flush && !stall;
  assign move     = (do_push || do_flush) && pend_valid_q;

  assign stat_o.stall      = stall;
  assign stat_o.pend_valid = pend_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end
      if (do_push) begin
        pend_valid_q <= 1'b1;
      end else if (do_flush) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q      <= pend_q;
      out_last_q <= do_flush;
    end
    if (do_push) begin
      pend_q <= ctl_i.res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign expired_timer_o = out_q.timer;
  assign tick_count_o    = out_q.count;
  assign last_o          = out_last_q;

  `PTB_ASSERT_NEXT(a_push_holds, clk_i, rst_ni, do_push, pend_valid_q)
  `PTB_ASSERT_NEXT(a_flush_empties, clk_i, rst_ni, do_flush, !pend_valid_q)
  `PTB_ASSERT_NEXT(a_push_moves, clk_i, rst_ni, do_push && pend_valid_q,
                   out_valid_q && !out_last_q)

endmodule
`default_nettype wire

// ===== hdl/periodic_timer_bank.sv =====
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    action_i, timer_id_i, now_us_i, callback_enable_i
// out      out_valid_o / out_ready_i  expired_timer_o, tick_count_o, last_o
// cfg      cfg_we_i                   cfg_wdata_i (tick_period_us)
//
// Init, reset, stop and set-callback words are handled in S_IDLE without leaving it.
// A poll scans every timer, loads and catches up each active one (one expiry per
// cycle through the shared 64-bit compare and add, unless output stalls), then flushes.
// Deadlines and counts sit in two RAMs with registered reads; flags are flops.
// Reset sets period to PERIOD_RESET, clears flags and control; RAM contents need no clearing.
// Output back-pressure stalls the catch-up loop only when a word must move.
`default_nettype none
`include "periodic_timer_bank_macros.svh"
module periodic_timer_bank #(
  parameter int unsigned NUM_TIMERS    = 8,
  parameter int unsigned CATCHUP_LIMIT = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ptb_pkg::COUNT_W-1:0] cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [ptb_pkg::ACT_W-1:0]   action_i,
  input  wire logic [ptb_pkg::TIMER_W-1:0] timer_id_i,
  input  wire logic [ptb_pkg::TIME_W-1:0]  now_us_i,
  input  wire logic                        callback_enable_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [ptb_pkg::TIMER_W-1:0]      expired_timer_o,
  output logic [ptb_pkg::COUNT_W-1:0]      tick_count_o,
  output logic                             last_o
);
  import ptb_pkg::*;

  localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned KW    = $clog2(CATCHUP_LIMIT + 1);
  localparam int unsigned EXT_W = IDX_W + TIMER_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
  localparam logic [KW-1:0]    K_LIMIT  = KW'(CATCHUP_LIMIT);

  ptb_state_e state_q, state_d;
  logic [COUNT_W-1:0]    period_q;
  logic [NUM_TIMERS-1:0] reg_q, reg_d, run_q, run_d, rep_q, rep_d;
  logic [IDX_W-1:0]      i_q, i_d;
  logic [KW-1:0]         k_q, k_d;
  logic [TIME_W-1:0]     now_q, now_d;
  logic [TIME_W-1:0]     dl_q, dl_d;
  logic [COUNT_W-1:0]    cnt_q, cnt_d;

  logic                  dl_we, cnt_we;
  logic [IDX_W-1:0]      waddr;
  logic [TIME_W-1:0]     dl_wdata, dl_rdata;
  logic [COUNT_W-1:0]    cnt_wdata, cnt_rdata;

  logic [EXT_W-1:0]      id_ext, i_ext;
  logic [IDX_W-1:0]      idx;
  logic                  id_ok;
  logic                  hit;
  logic [TIME_W-1:0]     dl_next;
  logic [COUNT_W-1:0]    cnt_next;
  ptb_out_ctl_t          out_ctl;
  ptb_out_stat_t         out_stat;

  assign id_ext   = EXT_W'(timer_id_i);
  assign idx      = id_ext[IDX_W-1:0];
  assign i_ext    = EXT_W'(i_q);
  assign id_ok    = 32'(timer_id_i) < 32'(NUM_TIMERS);
  assign hit      = (k_q < K_LIMIT) && (now_q >= dl_q);
  assign dl_next  = dl_q + TIME_W'(period_q);
  assign cnt_next = cnt_q + COUNT_W'(1);

  always_comb begin
    state_d     = state_q;
    reg_d       = reg_q;
    run_d       = run_q;
    rep_d       = rep_q;
    i_d         = i_q;
    k_d         = k_q;
    now_d       = now_q;
    dl_d        = dl_q;
    cnt_d       = cnt_q;
    dl_we       = 1'b0;
    cnt_we      = 1'b0;
    waddr       = i_q;
    dl_wdata    = dl_q;
    cnt_wdata   = cnt_q;
    in_ready_o  = 1'b0;
    out_ctl.push      = 1'b0;
    out_ctl.flush     = 1'b0;
    out_ctl.res.timer = i_ext[TIMER_W-1:0];
    out_ctl.res.count = cnt_next;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          waddr = idx;
          case (ptb_action_e'(action_i))
            ACT_POLL: begin
              now_d   = now_us_i;
              i_d     = '0;
              state_d = S_SCAN;
            end
            ACT_INIT, ACT_RESET: begin
              if (id_ok) begin
                if (ptb_action_e'(action_i) == ACT_INIT) begin
                  reg_d[idx] = 1'b1;
                end
                run_d[idx] = 1'b1;
                dl_we      = 1'b1;
                dl_wdata   = now_us_i + TIME_W'(period_q);
                cnt_we     = 1'b1;
                cnt_wdata  = '0;
              end
            end
            ACT_STOP: begin
              if (id_ok) begin
                run_d[idx] = 1'b0;
                cnt_we     = 1'b1;
                cnt_wdata  = '0;
              end
            end
            ACT_SETCB: begin
              if (id_ok) begin
                rep_d[idx] = callback_enable_i;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (reg_q[i_q] && run_q[i_q]) begin
          state_d = S_LOAD;
        end else if (i_q == LAST_IDX) begin
          state_d = S_FLUSH;
        end else begin
          i_d = i_q + IDX_W'(1);
        end
      end
      S_LOAD: begin
        dl_d    = dl_rdata;
        cnt_d   = cnt_rdata;
        k_d     = '0;
        state_d = S_CATCH;
      end
      S_CATCH: begin
        if (hit) begin
          if (!(rep_q[i_q] && out_stat.stall)) begin
            out_ctl.push = rep_q[i_q];
            dl_d  = dl_next;
            cnt_d = cnt_next;
            k_d   = k_q + KW'(1);
          end
        end else begin
          dl_we  = 1'b1;
          cnt_we = 1'b1;
          if (i_q == LAST_IDX) begin
            state_d = S_FLUSH;
          end else begin
            i_d     = i_q + IDX_W'(1);
            state_d = S_SCAN;
          end
        end
      end
      S_FLUSH: begin
        if (!out_stat.stall) begin
          out_ctl.flush = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      period_q <= PERIOD_RESET;
      reg_q    <= '0;
      run_q    <= '0;
      rep_q    <= '0;
      i_q      <= '0;
      k_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      reg_q <= reg_d;
      run_q <= run_d;
      rep_q <= rep_d;
      i_q   <= i_d;
      k_q   <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    dl_q  <= dl_d;
    cnt_q <= cnt_d;
  end

  ptb_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_TIMERS),
    .AW    (IDX_W)
  ) u_dl_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (waddr),
    .wdata_i (dl_wdata),
    .raddr_i (i_q),
    .rdata_o (dl_rdata)
  );

  ptb_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_TIMERS),
    .AW    (IDX_W)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (i_q),
    .rdata_o (cnt_rdata)
  );

  ptb_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (out_ctl),
    .stat_o          (out_stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .expired_timer_o (expired_timer_o),
    .tick_count_o    (tick_count_o),
    .last_o          (last_o)
  );

  `PTB_ASSERT(a_k_bound, clk_i, rst_ni, k_q <= K_LIMIT)
  `PTB_ASSERT(a_catch_active, clk_i, rst_ni,
              (state_q == S_CATCH) |-> (reg_q[i_q] && run_q[i_q]))
  `PTB_ASSERT(a_idle_no_pend, clk_i, rst_ni, (state_q == S_IDLE) |-> !out_stat.pend_valid)

endmodule
`default_nettype wire
